### hw/rtl/xthd_pkg.sv
// Shared types, constants and the key ROM for the type-7 text decoder.
`default_nettype none
package xthd_pkg;

	localparam int KEY_LENGTH = 53;
	localparam int KEY_IDX_W  = 6;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_END_NO_BYTE = 2'd1;
	localparam logic [1:0] ST_BAD_LENGTH  = 2'd2;
	localparam logic [1:0] ST_BAD_DIGIT   = 2'd3;

	// One decoded word on its way from front to back.
	typedef struct packed {
		logic [7:0]           data;     // byte before the key XOR, 0 on error words
		logic [KEY_IDX_W-1:0] key_idx;
		logic                 xor_en;
		logic [1:0]           status;
		logic                 eos;
	} res_word_t;

	function automatic logic [7:0] key_rom(input logic [KEY_IDX_W-1:0] idx);
		logic [7:0] k;
		begin
			case (idx)
				6'd0:  k = 8'h64; 6'd1:  k = 8'h73; 6'd2:  k = 8'h66; 6'd3:  k = 8'h64;
				6'd4:  k = 8'h3b; 6'd5:  k = 8'h6b; 6'd6:  k = 8'h66; 6'd7:  k = 8'h6f;
				6'd8:  k = 8'h41; 6'd9:  k = 8'h2c; 6'd10: k = 8'h2e; 6'd11: k = 8'h69;
				6'd12: k = 8'h79; 6'd13: k = 8'h65; 6'd14: k = 8'h77; 6'd15: k = 8'h72;
				6'd16: k = 8'h6b; 6'd17: k = 8'h6c; 6'd18: k = 8'h64; 6'd19: k = 8'h4a;
				6'd20: k = 8'h4b; 6'd21: k = 8'h44; 6'd22: k = 8'h48; 6'd23: k = 8'h53;
				6'd24: k = 8'h55; 6'd25: k = 8'h42; 6'd26: k = 8'h73; 6'd27: k = 8'h67;
				6'd28: k = 8'h76; 6'd29: k = 8'h63; 6'd30: k = 8'h61; 6'd31: k = 8'h36;
				6'd32: k = 8'h39; 6'd33: k = 8'h38; 6'd34: k = 8'h33; 6'd35: k = 8'h34;
				6'd36: k = 8'h6e; 6'd37: k = 8'h63; 6'd38: k = 8'h78; 6'd39: k = 8'h76;
				6'd40: k = 8'h39; 6'd41: k = 8'h38; 6'd42: k = 8'h37; 6'd43: k = 8'h33;
				6'd44: k = 8'h32; 6'd45: k = 8'h35; 6'd46: k = 8'h34; 6'd47: k = 8'h6b;
				6'd48: k = 8'h3b; 6'd49: k = 8'h66; 6'd50: k = 8'h67; 6'd51: k = 8'h38;
				6'd52: k = 8'h37;
				default: k = 8'h00;
			endcase
			return k;
		end
	endfunction

	// {ok, value}: ok is 0 for anything outside 0-9.
	function automatic logic [4:0] dec_digit(input logic [7:0] c);
		logic [4:0] r;
		begin
			r = 5'd0;
			if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
			return r;
		end
	endfunction

	// {ok, value}: ok is 0 for anything outside 0-9, a-f, A-F.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		begin
			r = 5'd0;
			if (c >= 8'h30 && c <= 8'h39)
				r = {1'b1, 4'(c - 8'h30)};
			else if (c >= 8'h61 && c <= 8'h66)
				r = {1'b1, 4'(c - 8'h57)};
			else if (c >= 8'h41 && c <= 8'h46)
				r = {1'b1, 4'(c - 8'h37)};
			return r;
		end
	endfunction

endpackage
`default_nettype wire

### hw/rtl/xor_table_password_hex_decoder_unit.sv
// Top level of the type-7 password text decoder.
`default_nettype none
// Decodes type-7 obfuscated password text, one ASCII character per push word,
// with final_char set on the last one. Two decimal index digits pick the start
// point in a 53-byte key table; each following hex pair yields one plain byte,
// XORed with the key and popped as one result word. The final character always
// yields one word with end_of_string set and a status: 0 with the last byte,
// 2 for a length under 4 or odd, 3 for a non-digit character. Characters
// that fail a check give no words until the final one. One character is taken
// every cycle while full is low; the parse state updates in the accepting cycle
// and a result word reaches the pop side through a four-word queue and an
// output register. full rises only when the queue is full, i.e. when the pop
// side has stalled.
module xor_table_password_hex_decoder_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] text_char,
	input  wire logic       final_char,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      plain_byte,
	output logic [1:0]      status,
	output logic            end_of_string
);
	import xthd_pkg::*;

	logic      accept;
	logic      word_valid;
	res_word_t front_word;
	res_word_t q_word;
	logic      q_full, q_empty, q_pop;

	assign full   = q_full;
	assign accept = push && !q_full;

	xthd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.text_char  (text_char),
		.final_char (final_char),
		.word_valid (word_valid),
		.word       (front_word)
	);

	xthd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (word_valid),
		.wr_word (front_word),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_word (q_word),
		.empty   (q_empty)
	);

	xthd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_word        (q_word),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.plain_byte    (plain_byte),
		.status        (status),
		.end_of_string (end_of_string)
	);

endmodule
`default_nettype wire

### hw/rtl/xthd_front.sv
// Front end: takes characters, tracks parse state, builds decode words.
`default_nettype none
module xthd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        text_char,
	input  wire logic              final_char,
	output logic                   word_valid,
	output xthd_pkg::res_word_t    word
);
	import xthd_pkg::*;

	localparam logic [1:0] PH_IDX_HI = 2'd0;
	localparam logic [1:0] PH_IDX_LO = 2'd1;
	localparam logic [1:0] PH_HEX_HI = 2'd2;
	localparam logic [1:0] PH_HEX_LO = 2'd3;

	logic [1:0]           phase_q, phase_d;
	logic [3:0]           tens_q, tens_d;
	logic [3:0]           high_q, high_d;
	logic [KEY_IDX_W-1:0] key_idx_q, key_idx_d;
	logic                 odd_q, odd_d;
	logic                 saw_q, saw_d;
	logic                 err_q, err_d;

	logic [4:0]           dec, hex;
	logic [3:0]           dec_v, hex_v;
	logic [6:0]           start_sum;
	logic [KEY_IDX_W-1:0] start_idx, idx_inc;
	logic                 have_byte;
	logic [7:0]           pair_byte;
	logic [1:0]           status;

	assign dec   = dec_digit(text_char);
	assign hex   = hex_digit(text_char);
	assign dec_v = dec[4] ? dec[3:0] : 4'd0;
	assign hex_v = hex[4] ? hex[3:0] : 4'd0;

	// tens*10 + ones is below 100, so one conditional subtract reduces it
	assign start_sum = {tens_q, 3'b000} + {2'b00, tens_q, 1'b0} + {3'b000, dec_v};
	assign start_idx = (start_sum >= 7'(KEY_LENGTH)) ?
		KEY_IDX_W'(start_sum - 7'(KEY_LENGTH)) : KEY_IDX_W'(start_sum);
	assign idx_inc = (7'(key_idx_q) + 7'd1 >= 7'(KEY_LENGTH)) ?
		'0 : key_idx_q + KEY_IDX_W'(1);
	assign pair_byte = {high_q, hex_v};

	always_comb begin
		phase_d   = phase_q;
		tens_d    = tens_q;
		high_d    = high_q;
		key_idx_d = key_idx_q;
		saw_d     = saw_q;
		err_d     = err_q;
		have_byte = 1'b0;
		case (phase_q)
			PH_IDX_HI: begin
				tens_d  = dec_v;
				err_d   = err_q | ~dec[4];
				phase_d = PH_IDX_LO;
			end
			PH_IDX_LO: begin
				key_idx_d = start_idx;
				err_d     = err_q | ~dec[4];
				phase_d   = PH_HEX_HI;
			end
			PH_HEX_HI: begin
				high_d  = hex_v;
				err_d   = err_q | ~hex[4];
				phase_d = PH_HEX_LO;
			end
			PH_HEX_LO: begin
				err_d     = err_q | ~hex[4];
				have_byte = 1'b1;
				key_idx_d = idx_inc;
				saw_d     = 1'b1;
				phase_d   = PH_HEX_HI;
			end
			default: begin
				phase_d = PH_IDX_HI;
			end
		endcase
		odd_d = ~odd_q;

		if (odd_d || !saw_d)
			status = ST_BAD_LENGTH;
		else if (err_d)
			status = ST_BAD_DIGIT;
		else if (have_byte)
			status = ST_OK;
		else
			status = ST_END_NO_BYTE;

		if (!final_char)
			status = ST_OK;
	end

	assign word_valid   = accept && (final_char || (have_byte && !err_d));
	assign word.data    = (status == ST_OK) ? pair_byte : 8'h00;
	assign word.key_idx = key_idx_q;
	assign word.xor_en  = (status == ST_OK);
	assign word.status  = status;
	assign word.eos     = final_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDX_HI;
			tens_q    <= '0;
			high_q    <= '0;
			key_idx_q <= '0;
			odd_q     <= 1'b0;
			saw_q     <= 1'b0;
			err_q     <= 1'b0;
		end else if (accept) begin
			if (final_char) begin
				phase_q   <= PH_IDX_HI;
				tens_q    <= '0;
				high_q    <= '0;
				key_idx_q <= '0;
				odd_q     <= 1'b0;
				saw_q     <= 1'b0;
				err_q     <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				tens_q    <= tens_d;
				high_q    <= high_d;
				key_idx_q <= key_idx_d;
				odd_q     <= odd_d;
				saw_q     <= saw_d;
				err_q     <= err_d;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/xthd_fifo.sv
// Short queue of decode words between front and back.
`default_nettype none
module xthd_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire xthd_pkg::res_word_t wr_word,
	output logic                   full,
	input  wire logic              rd_en,
	output xthd_pkg::res_word_t    rd_word,
	output logic                   empty
);
	import xthd_pkg::*;

	res_word_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;
	logic                  do_wr, do_rd;

	assign full    = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + (FIFO_PTR_W+1)'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - (FIFO_PTR_W+1)'(1);
		end
	end

endmodule
`default_nettype wire

### hw/rtl/xthd_back.sv
// Back end: key ROM lookup, XOR, and the output word register.
`default_nettype none
module xthd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire xthd_pkg::res_word_t q_word,
	output logic                   q_pop,
	input  wire logic              pop,
	output logic                   empty,
	output logic [7:0]             plain_byte,
	output logic [1:0]             status,
	output logic                   end_of_string
);
	import xthd_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] status_q;
	logic       eos_q;
	logic [7:0] key;

	assign key   = key_rom(q_word.key_idx);
	// refill the output register whenever it is free or being drained
	assign q_pop = !q_empty && (!valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q   <= q_word.xor_en ? (q_word.data ^ key) : q_word.data;
			status_q <= q_word.status;
			eos_q    <= q_word.eos;
		end
	end

	assign empty         = !valid_q;
	assign plain_byte    = byte_q;
	assign status        = status_q;
	assign end_of_string = eos_q;

endmodule
`default_nettype wire
